>>> rtl/cbs_pkg.sv
// Shared types and constants of the cubic B-spline sampler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbs_pkg;

  localparam int SEG_WIDTH   = 6;
  localparam int U_WIDTH     = 16;
  localparam int V_WIDTH     = 17;
  localparam int QUO_WIDTH   = 17;
  localparam int DIV_STEPS   = 17;
  localparam int CNT_WIDTH   = 5;
  localparam int W_WIDTH     = 27;
  localparam int BW          = 52;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_STAGES  = 11;

  localparam logic [SEG_WIDTH-1:0] SEG_RESET     = 6'd12;
  localparam logic [SEG_WIDTH-1:0] SEG_ONE       = 6'd1;
  localparam logic [QUO_WIDTH-1:0] DIV_DIVIDEND  = 17'h10000;
  localparam logic [V_WIDTH-1:0]   U_ONE         = 17'h10000;
  localparam logic [BW-1:0]        ONE_Q48       = 52'h1_0000_0000_0000;
  localparam logic [BW-1:0]        ROUND_Q24     = 52'h0_0000_0080_0000;
  localparam logic [W_WIDTH-1:0]   W_PASS        = 27'd100663296;

  typedef struct packed {
    logic pe;
    logic last;
  } cbs_ctl_t;

endpackage

`default_nettype wire

>>> rtl/cbs_front.sv
// Front end: accepts control points, keeps the three previous points and
// queues a span job once a path has four points. Depends on cbs_pkg.
`default_nettype none

module cbs_front import cbs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [COORD_WIDTH-1:0]   in_point_x,
  input  wire logic [COORD_WIDTH-1:0]   in_point_y,
  input  wire logic                     in_final_point,
  input  wire logic                     q_full,
  output logic                          q_push,
  output logic [8*COORD_WIDTH:0]        q_wdata
);

  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic [COORD_WIDTH-1:0] win_x_r [3];
  logic [COORD_WIDTH-1:0] win_y_r [3];
  logic [1:0]             seen_r;
  logic [1:0]             seen_nxt;
  logic                   accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept & (seen_r == SEEN_FULL);
  assign q_wdata  = {in_final_point,
                     win_x_r[0], win_x_r[1], win_x_r[2], in_point_x,
                     win_y_r[0], win_y_r[1], win_y_r[2], in_point_y};

  always_comb begin
    if (in_final_point) begin
      seen_nxt = '0;
    end else if (seen_r == SEEN_FULL) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else if (accept) begin
      seen_r     <= seen_nxt;
      win_x_r[0] <= win_x_r[1];
      win_x_r[1] <= win_x_r[2];
      win_x_r[2] <= in_point_x;
      win_y_r[0] <= win_y_r[1];
      win_y_r[1] <= win_y_r[2];
      win_y_r[2] <= in_point_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cbs_queue.sv
// Small register FIFO that carries span jobs from the front end to the
// sample sequencer. Depends on cbs_pkg.
`default_nettype none

module cbs_queue import cbs_pkg::*; #(
  parameter int WIDTH = 193,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cbs_seq.sv
// Sample sequencer: holds the span count, derives the curve parameter step with a serial
// divider and, unless stalled or dividing, issues one sample per cycle. Depends on cbs_pkg.
`default_nettype none

module cbs_seq import cbs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [SEG_WIDTH-1:0]     cfg_wr_data,
  input  wire logic                     q_empty,
  input  wire logic [8*COORD_WIDTH:0]   q_rdata,
  output logic                          q_pop,
  input  wire logic                     adv,
  output logic                          issue_valid,
  output cbs_ctl_t                      issue_ctl,
  output logic [U_WIDTH-1:0]            issue_u,
  output logic [8*COORD_WIDTH-1:0]      issue_coords
);

  localparam int JW = 8 * COORD_WIDTH + 1;

  logic [SEG_WIDTH-1:0] seg_r;
  logic [SEG_WIDTH-1:0] seg_eff;
  logic                 div_start_r;
  logic [CNT_WIDTH-1:0] div_cnt_r;
  logic [QUO_WIDTH-1:0] div_quo_r;
  logic [SEG_WIDTH-1:0] div_rem_r;
  logic [SEG_WIDTH:0]   div_rem_sh;
  logic                 div_ge;
  logic [SEG_WIDTH-1:0] div_rem_nxt;
  logic [QUO_WIDTH-1:0] div_quo_nxt;
  logic                 div_busy;

  logic                 active_r;
  logic [JW-1:0]        job_r;
  logic [SEG_WIDTH-1:0] j_r;
  logic [U_WIDTH-1:0]   u_r;
  logic [SEG_WIDTH-1:0] ur_r;
  logic [SEG_WIDTH:0]   ur_sum;
  logic                 ur_carry;
  logic [SEG_WIDTH-1:0] ur_nxt;
  logic [U_WIDTH-1:0]   u_nxt;
  logic                 is_pe;
  logic                 is_last;
  logic                 done;
  logic                 load;

  assign seg_eff = (seg_r == '0) ? SEG_ONE : seg_r;

  assign div_busy    = div_start_r | (div_cnt_r != '0);
  assign div_rem_sh  = {div_rem_r, div_quo_r[QUO_WIDTH-1]};
  assign div_ge      = (div_rem_sh >= {1'b0, seg_eff});
  assign div_rem_nxt = div_ge ? SEG_WIDTH'(div_rem_sh - {1'b0, seg_eff})
                              : SEG_WIDTH'(div_rem_sh);
  assign div_quo_nxt = {div_quo_r[QUO_WIDTH-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_RESET;
      div_start_r <= 1'b1;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        seg_r <= cfg_wr_data;
      end
      div_start_r <= cfg_wr_en;
      if (div_start_r) begin
        div_cnt_r <= CNT_WIDTH'(DIV_STEPS);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - CNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start_r) begin
      div_quo_r <= DIV_DIVIDEND;
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      div_quo_r <= div_quo_nxt;
      div_rem_r <= div_rem_nxt;
    end
  end

  assign is_pe       = (j_r == seg_eff);
  assign is_last     = is_pe | ((j_r == seg_eff - SEG_ONE) & ~job_r[JW-1]);
  assign issue_valid = active_r & adv & ~div_busy;
  assign done        = issue_valid & is_last;
  assign load        = (~active_r | done) & ~q_empty;
  assign q_pop       = load;

  assign issue_ctl.pe   = is_pe;
  assign issue_ctl.last = is_last;
  assign issue_u        = u_r;
  assign issue_coords   = job_r[JW-2:0];

  assign ur_sum   = {1'b0, ur_r} + {1'b0, div_rem_r};
  assign ur_carry = (ur_sum >= {1'b0, seg_eff});
  assign ur_nxt   = ur_carry ? SEG_WIDTH'(ur_sum - {1'b0, seg_eff}) : SEG_WIDTH'(ur_sum);
  assign u_nxt    = U_WIDTH'({1'b0, u_r} + div_quo_r + QUO_WIDTH'(ur_carry));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (done) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_rdata;
      j_r   <= '0;
      u_r   <= '0;
      ur_r  <= '0;
    end else if (issue_valid) begin
      j_r  <= j_r + SEG_ONE;
      u_r  <= u_nxt;
      ur_r <= ur_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cbs_eval.sv
// Evaluation pipeline: basis weights, weighted sums, rounding division by
// six and saturation, ending in the output register. Depends on cbs_pkg.
`default_nettype none

module cbs_eval import cbs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output logic                          adv,
  input  wire logic                     issue_valid,
  input  wire cbs_ctl_t                 issue_ctl,
  input  wire logic [U_WIDTH-1:0]       issue_u,
  input  wire logic [8*COORD_WIDTH-1:0] issue_coords,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [COORD_WIDTH-1:0]        out_sample_x,
  output logic [COORD_WIDTH-1:0]        out_sample_y,
  output logic                          out_run_last,
  output logic                          out_path_end
);

  localparam int CW  = COORD_WIDTH;
  localparam int CRW = 8 * CW;
  localparam int PW  = CW + W_WIDTH + 1;
  localparam int AW  = CW + W_WIDTH + 3;
  localparam int TW  = AW - 24;
  localparam logic [AW:0]   RND     = (AW+1)'(64'd3 << 24);
  localparam logic [CW:0]   T_CLAMP = (CW+1)'(64'd3 << (CW - 1));
  localparam logic [CW-1:0] DIV3_M  = CW'((64'd1 << (CW + 1)) / 64'd3);
  localparam logic [CW:0]   HALF    = (CW+1)'(64'd1 << (CW - 1));
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};

  logic     vld_r [NUM_STAGES];
  cbs_ctl_t ctl_r [NUM_STAGES];
  logic [CRW-1:0] crd_r [4];

  logic [U_WIDTH-1:0]  u1_r;
  logic [V_WIDTH-1:0]  v1_r;
  logic [31:0]         usq1_r;
  logic [32:0]         vsq1_r;
  logic [U_WIDTH-1:0]  u2_r;
  logic [31:0]         usq2_r;
  logic [47:0]         ucb2_r;
  logic [48:0]         vcb2_r;
  logic [BW-1:0]       b3_r [4];
  logic [W_WIDTH-1:0]  w4_r [4];
  logic signed [PW-1:0] prod5_r [2][4];
  logic signed [AW-1:0] sum6_r [2][2];
  logic signed [AW-1:0] acc7_r [2];
  logic [AW-1:0]       mag8_r [2];
  logic                neg8_r [2];
  logic [CW:0]         t9_r [2];
  logic                neg9_r [2];
  logic [CW:0]         t10_r [2];
  logic [CW-1:0]       qe10_r [2];
  logic                neg10_r [2];
  logic [CW-1:0]       smp_r [2];

  logic [V_WIDTH-1:0]  v_nxt;
  logic [31:0]         usq_nxt;
  logic [33:0]         vsq_full;
  logic [47:0]         ucb_nxt;
  logic [49:0]         vcb_full;
  logic [BW-1:0]       b_nxt [4];
  logic [BW-1:0]       wr_sum [4];
  logic [W_WIDTH-1:0]  w_nxt [4];
  logic signed [PW-1:0] prod_nxt [2][4];
  logic signed [AW-1:0] sum_nxt [2][2];
  logic signed [AW-1:0] acc_nxt [2];
  logic [AW-1:0]       mag_nxt [2];
  logic [AW:0]         tsum [2];
  logic [TW-1:0]       tfull [2];
  logic [CW:0]         t_nxt [2];
  logic [2*CW:0]       dprod [2];
  logic [CW:0]         rem3 [2];
  logic [CW:0]         q_fix [2];
  logic [CW-1:0]       smp_nxt [2];

  assign adv          = ~(vld_r[NUM_STAGES-1] & out_stall);
  assign out_valid    = vld_r[NUM_STAGES-1];
  assign out_run_last = ctl_r[NUM_STAGES-1].last;
  assign out_path_end = ctl_r[NUM_STAGES-1].pe;
  assign out_sample_x = smp_r[0];
  assign out_sample_y = smp_r[1];

  assign v_nxt    = U_ONE - {1'b0, issue_u};
  assign usq_nxt  = issue_u * issue_u;
  assign vsq_full = v_nxt * v_nxt;
  assign ucb_nxt  = usq1_r * u1_r;
  assign vcb_full = vsq1_r * v1_r;

  always_comb begin
    logic [BW-1:0] u3e;
    logic [BW-1:0] u2s;
    logic [BW-1:0] u1s;
    u3e = BW'(ucb2_r);
    u2s = BW'(usq2_r) << 16;
    u1s = BW'(u2_r) << 32;
    b_nxt[0] = BW'(vcb2_r);
    b_nxt[1] = (ONE_Q48 << 2) + 3 * u3e - 6 * u2s;
    b_nxt[2] = ONE_Q48 + 3 * u1s + 3 * u2s - 3 * u3e;
    b_nxt[3] = u3e;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      wr_sum[k] = b3_r[k] + ROUND_Q24;
      w_nxt[k]  = wr_sum[k][50:24];
    end
    if (ctl_r[2].pe) begin
      w_nxt[0] = '0;
      w_nxt[1] = '0;
      w_nxt[2] = '0;
      w_nxt[3] = W_PASS;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 4; k++) begin
        prod_nxt[l][k] = $signed({1'b0, w4_r[k]})
                       * $signed(crd_r[3][((1 - l) * 4 + (3 - k)) * CW +: CW]);
      end
      sum_nxt[l][0] = AW'(prod5_r[l][0]) + AW'(prod5_r[l][1]);
      sum_nxt[l][1] = AW'(prod5_r[l][2]) + AW'(prod5_r[l][3]);
      acc_nxt[l]    = sum6_r[l][0] + sum6_r[l][1];
      mag_nxt[l]    = acc7_r[l][AW-1] ? AW'(-acc7_r[l]) : AW'(acc7_r[l]);
      tsum[l]       = {1'b0, mag8_r[l]} + RND;
      tfull[l]      = tsum[l][AW:25];
      t_nxt[l]      = (tfull[l] > TW'(T_CLAMP)) ? T_CLAMP : (CW+1)'(tfull[l]);
      dprod[l]      = (2*CW+1)'(t9_r[l]) * (2*CW+1)'(DIV3_M);
      rem3[l]       = t10_r[l] - {qe10_r[l], 1'b0} - {1'b0, qe10_r[l]};
      q_fix[l]      = {1'b0, qe10_r[l]} + ((rem3[l] >= (CW+1)'(3)) ? (CW+1)'(1) : '0);
      if (neg10_r[l]) begin
        smp_nxt[l] = CW'(-q_fix[l]);
      end else if (q_fix[l] >= HALF) begin
        smp_nxt[l] = POS_MAX;
      end else begin
        smp_nxt[l] = q_fix[l][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= issue_valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= issue_ctl;
      for (int s = 1; s < NUM_STAGES; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      crd_r[0] <= issue_coords;
      for (int s = 1; s < 4; s++) begin
        crd_r[s] <= crd_r[s-1];
      end
      u1_r   <= issue_u;
      v1_r   <= v_nxt;
      usq1_r <= usq_nxt;
      vsq1_r <= vsq_full[32:0];
      u2_r   <= u1_r;
      usq2_r <= usq1_r;
      ucb2_r <= ucb_nxt;
      vcb2_r <= vcb_full[48:0];
      for (int k = 0; k < 4; k++) begin
        b3_r[k] <= b_nxt[k];
        w4_r[k] <= w_nxt[k];
      end
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 4; k++) begin
          prod5_r[l][k] <= prod_nxt[l][k];
        end
        sum6_r[l][0] <= sum_nxt[l][0];
        sum6_r[l][1] <= sum_nxt[l][1];
        acc7_r[l]    <= acc_nxt[l];
        mag8_r[l]    <= mag_nxt[l];
        neg8_r[l]    <= acc7_r[l][AW-1];
        t9_r[l]      <= t_nxt[l];
        neg9_r[l]    <= neg8_r[l];
        t10_r[l]     <= t9_r[l];
        qe10_r[l]    <= dprod[l][2*CW:CW+1];
        neg10_r[l]   <= neg9_r[l];
        smp_r[l]     <= smp_nxt[l];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/cubic_bspline_sampler.sv
// Top level of the uniform cubic B-spline sampler.
// Depends on cbs_pkg, cbs_front, cbs_queue, cbs_seq and cbs_eval.
//
// Control points enter on the in_ channel (valid/stall); a transaction takes
// place when in_valid is high and in_stall is low. From the fourth point of
// a path on, each point yields segments_per_span samples on the out_ channel,
// one per cycle unless a stall or the divider holds them, plus one closing
// sample equal to the point itself when the point carries in_final_point.
// out_run_last marks the last sample of each point and out_path_end the
// closing sample. A span count of zero acts as one. The span count is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce. After reset or
// a write, a serial divider derives the parameter step; samples are not
// issued until it finishes, while input points are still taken into the job
// queue. The sequencer issues one sample per cycle unless the pipeline is frozen
// or the divider is busy; samples then pass through the 11-stage evaluation
// pipeline. When out_stall holds a sample, the whole pipeline freezes; input
// points keep flowing until the two-entry job queue is full. Reset clears the
// point window, the path count and the pipeline, and sets the span count to 12.
`default_nettype none

module cubic_bspline_sampler import cbs_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [SEG_WIDTH-1:0]   cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [COORD_WIDTH-1:0] in_point_x,
  input  wire logic [COORD_WIDTH-1:0] in_point_y,
  input  wire logic                   in_final_point,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COORD_WIDTH-1:0]      out_sample_x,
  output logic [COORD_WIDTH-1:0]      out_sample_y,
  output logic                        out_run_last,
  output logic                        out_path_end
);

  localparam int JW = 8 * COORD_WIDTH + 1;

  logic                     q_full;
  logic                     q_empty;
  logic                     q_push;
  logic                     q_pop;
  logic [JW-1:0]            q_wdata;
  logic [JW-1:0]            q_rdata;
  logic                     adv;
  logic                     issue_valid;
  cbs_ctl_t                 issue_ctl;
  logic [U_WIDTH-1:0]       issue_u;
  logic [JW-2:0]            issue_coords;

  cbs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_final_point (in_final_point),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  cbs_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cbs_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .adv          (adv),
    .issue_valid  (issue_valid),
    .issue_ctl    (issue_ctl),
    .issue_u      (issue_u),
    .issue_coords (issue_coords)
  );

  cbs_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .issue_valid  (issue_valid),
    .issue_ctl    (issue_ctl),
    .issue_u      (issue_u),
    .issue_coords (issue_coords),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample_x (out_sample_x),
    .out_sample_y (out_sample_y),
    .out_run_last (out_run_last),
    .out_path_end (out_path_end)
  );

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("sample presented right after reset");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_path_end) |-> out_run_last)
    else $error("closing sample not marked as last of its point");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job taken from an empty queue");

  a_issue_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    issue_valid |-> adv)
    else $error("sample issued while the pipeline is frozen");

endmodule

`default_nettype wire

>>> bench/cubic_bspline_sampler_tb.sv
// Self-checking testbench for the cubic B-spline sampler: it drives control point paths,
// predicts every curve sample in its own fixed-point model and checks the sample stream.
// Depends on cbs_pkg and cubic_bspline_sampler.
module cubic_bspline_sampler_tb import cbs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint BLEND_DIV = 6 * (longint'(1) <<< 24);
  localparam logic [CW-1:0] XMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] XMIN = {1'b1, {(CW - 1){1'b0}}};
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          run_last;
    logic          path_end;
  } sample_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [SEG_WIDTH-1:0] cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [CW-1:0]        in_point_x;
  logic [CW-1:0]        in_point_y;
  logic                 in_final_point;
  logic                 out_valid;
  logic                 out_stall;
  logic [CW-1:0]        out_sample_x;
  logic [CW-1:0]        out_sample_y;
  logic                 out_run_last;
  logic                 out_path_end;

  sample_t              expected_samples[$];
  logic [SEG_WIDTH-1:0] span_count;
  logic [CW-1:0]        hist_x[3];
  logic [CW-1:0]        hist_y[3];
  int                   path_points;
  int                   mismatches;
  int                   quiet_cycles;
  int                   hold_request;
  bit                   tx_idling;
  bit                   rx_idling;

  cubic_bspline_sampler #(.COORD_WIDTH(CW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_x   (out_sample_x),
    .out_sample_y   (out_sample_y),
    .out_run_last   (out_run_last),
    .out_path_end   (out_path_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return XMAX;
    if (r < 16) return XMIN;
    if (r < 45) return CW'($urandom_range(0, 32767)) - CW'(16384);
    return CW'($urandom());
  endfunction

  function automatic longint unsigned weight_q24(longint unsigned b);
    return (b + (64'd1 << 23)) >> 24;
  endfunction

  function automatic logic [CW-1:0] blend_axis(longint w0, longint w1, longint w2, longint w3,
                                               logic [CW-1:0] a, logic [CW-1:0] b,
                                               logic [CW-1:0] c, logic [CW-1:0] d);
    longint          acc;
    longint unsigned mag;
    longint          q;
    acc = w0 * longint'($signed(a)) + w1 * longint'($signed(b))
        + w2 * longint'($signed(c)) + w3 * longint'($signed(d));
    mag = (acc < 0) ? -acc : acc;
    q = longint'((mag + BLEND_DIV / 2) / BLEND_DIV);
    if (acc < 0) q = -q;
    if (q > COORD_MAX) q = COORD_MAX;
    if (q < COORD_MIN) q = COORD_MIN;
    return q[CW-1:0];
  endfunction

  function automatic void queue_expected(sample_t s);
    expected_samples.insert(expected_samples.size(), s);
  endfunction

  function automatic void predict_samples(logic [CW-1:0] px, logic [CW-1:0] py, logic fin);
    longint unsigned seg;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned v;
    longint unsigned one;
    longint          w0;
    longint          w1;
    longint          w2;
    longint          w3;
    sample_t         s;
    seg = (span_count == 0) ? 1 : span_count;
    one = 64'd1 << 48;
    if (path_points >= 3) begin
      for (longint unsigned j = 0; j < seg; j++) begin
        u = (j << 16) / seg;
        u2 = u * u;
        u3 = u2 * u;
        v = 64'd65536 - u;
        w0 = weight_q24(v * v * v);
        w1 = weight_q24(4 * one + 3 * u3 - 6 * (u2 << 16));
        w2 = weight_q24(one + 3 * (u << 32) + 3 * (u2 << 16) - 3 * u3);
        w3 = weight_q24(u3);
        s.x = blend_axis(w0, w1, w2, w3, hist_x[0], hist_x[1], hist_x[2], px);
        s.y = blend_axis(w0, w1, w2, w3, hist_y[0], hist_y[1], hist_y[2], py);
        s.run_last = (j == seg - 1) && !fin;
        s.path_end = 1'b0;
        queue_expected(s);
      end
      if (fin) begin
        s.x = px;
        s.y = py;
        s.run_last = 1'b1;
        s.path_end = 1'b1;
        queue_expected(s);
      end
    end
    hist_x[0] = hist_x[1];
    hist_x[1] = hist_x[2];
    hist_x[2] = px;
    hist_y[0] = hist_y[1];
    hist_y[1] = hist_y[2];
    hist_y[2] = py;
    if (fin) path_points = 0;
    else if (path_points < 3) path_points++;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_sample(sample_t got);
    sample_t want;
    if (expected_samples.size() == 0) begin
      note_mismatch($sformatf("unexpected sample x=%h y=%h run_last=%b path_end=%b",
                              got.x, got.y, got.run_last, got.path_end));
    end else begin
      want = expected_samples.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.run_last !== want.run_last ||
          got.path_end !== want.path_end) begin
        note_mismatch($sformatf(
          "mismatch: expected x=%h y=%h last=%b end=%b, got x=%h y=%h last=%b end=%b",
          want.x, want.y, want.run_last, want.path_end,
          got.x, got.y, got.run_last, got.path_end));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_sample('{out_sample_x, out_sample_y, out_run_last, out_path_end});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idling && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left = pick_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic fin);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_final_point <= fin;
    do @(posedge clk); while (in_stall);
    predict_samples(px, py, fin);
    gap = (tx_idling && $urandom_range(0, 99) < 40) ? pick_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_path(int len, bit close);
    for (int i = 0; i < len; i++) send_point(rand_coord(), rand_coord(), close && i == len - 1);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_span(logic [SEG_WIDTH-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    span_count = value;
  endtask

  task automatic test_coordinate_extremes();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    send_point(XMAX, XMIN, 1'b0);
    send_point(XMIN, XMAX, 1'b0);
    send_point(XMAX, XMAX, 1'b0);
    send_point(XMAX, XMAX, 1'b0);
    send_point(XMIN, XMIN, 1'b0);
    send_point(XMIN, XMIN, 1'b1);
  endtask

  task automatic test_short_paths();
    send_path(1, 1'b1);
    send_path(2, 1'b1);
    send_path(3, 1'b1);
  endtask

  task automatic test_span_extremes();
    set_span('0);
    send_path(4, 1'b1);
    set_span('1);
    send_path(4, 1'b1);
  endtask

  task automatic test_backpressure();
    set_span(SEG_RESET);
    tx_idling = 1'b0;
    hold_request = HOLD_CYCLES;
    send_path(10, 1'b1);
  endtask

  task automatic run_phase(logic [SEG_WIDTH-1:0] span, int n_items, bit idle_on, bit pause_mid);
    int  sent;
    int  r;
    int  len;
    bit  close;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    set_span(span);
    tx_idling = idle_on;
    rx_idling = idle_on;
    while (sent < n_items) begin
      if (pause_mid && !paused && sent >= n_items / 2) begin
        wait_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        len = $urandom_range(1, 3);
        close = 1'b1;
      end else begin
        len = $urandom_range(4, 10);
        close = (r < 88);
      end
      send_path(len, close);
      sent += len;
    end
  endtask

  task automatic test_random_paths();
    run_phase(SEG_ONE, 10, 1'b1, 1'b0);
    run_phase(SEG_WIDTH'($urandom_range(2, 20)), 12, 1'b0, 1'b0);
    run_phase('1, 8, 1'b1, 1'b0);
    run_phase(SEG_WIDTH'($urandom_range(2, 16)), 12, 1'b1, 1'b1);
    run_phase(SEG_WIDTH'($urandom_range(0, 8)), 10, 1'b1, 1'b0);
    run_phase(SEG_RESET, 10, 1'b1, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_final_point = 1'b0;
    span_count = SEG_RESET;
    hist_x = '{default: '0};
    hist_y = '{default: '0};
    path_points = 0;
    mismatches = 0;
    hold_request = 0;
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_coordinate_extremes();
    test_short_paths();
    test_span_extremes();
    test_backpressure();
    test_random_paths();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
